@@ src/pau_pkg.sv @@
// ----------------------------------------------------------------------------
// pau_pkg: shared types and constants for the Pareto archive update block
// Archive sizing, field widths, controller states and the command and status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package pau_pkg;

  // archive sizing
  localparam int ARCHIVE_DEPTH = 64;
  localparam int IDX_W         = $clog2(ARCHIVE_DEPTH);
  localparam int CNT_W         = $clog2(ARCHIVE_DEPTH + 1);

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int SUM_W   = DATA_W + 1;
  localparam int EPS_W   = 16;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_PRIME,
    ST_STREAM
  } pau_state_t;

  typedef struct packed {
    logic start;   // load candidate, clear scan state
    logic scan;    // run read / compare / compact pipeline
    logic append;  // append candidate or flag overflow
    logic prime;   // fetch entry 0 into the output register
    logic stream;  // step the output stream on each taken request
  } pau_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic empty;
    logic stream_end;
  } pau_stat_t;

endpackage

@@ src/pareto_archive_update.sv @@
// ----------------------------------------------------------------------------
// pareto_archive_update: two-objective epsilon Pareto archive
// Updates an ordered archive of non-dominated candidates with each request
// and streams the whole archive back after every update.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per candidate (makespan, energy, unsigned Q28.4).
//            in_ready is high only while the block is idle; one request is
//            worked on at a time.
//   out_*  : after each update, one request per archive entry in archive
//            order; out_last_entry marks the final one. The summary fields
//            (accepted, removed_count, archive_count, overflow) repeat on
//            every entry of the same update.
//   cfg_*  : writes the epsilon margin; always ready, write only when idle.
// Sequence: the scan makes one memory read per entry; the compare and the
//   compaction write work on the registered read data, and the scan ends
//   once that pipeline is empty. Then the candidate is appended, entry 0 is
//   fetched and the stream sends one entry per cycle while out_ready is high,
//   before the block goes idle to take the next request. The single read
//   port of the archive memory is shared by the scan and the stream.
// Reset: clears the archive count and the handshake state and sets the
//   margin to 0.5; memory contents are not cleared.
// Stall: a low out_ready holds the current entry on out_* and halts the stream.
// ----------------------------------------------------------------------------
module pareto_archive_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pau_pkg::DATA_W-1:0]    in_cand_makespan,
  input  logic [pau_pkg::DATA_W-1:0]    in_cand_energy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pau_pkg::DATA_W-1:0]    out_entry_makespan,
  output logic [pau_pkg::DATA_W-1:0]    out_entry_energy,
  output logic [pau_pkg::SLOT_W-1:0]    out_entry_slot,
  output logic                          out_last_entry,
  output logic                          out_accepted,
  output logic [pau_pkg::COUNT_W-1:0]   out_removed_count,
  output logic [pau_pkg::COUNT_W-1:0]   out_archive_count,
  output logic                          out_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pau_pkg::EPS_W-1:0]     cfg_epsilon_margin
);

  pau_pkg::pau_cmd_t  cmd;
  pau_pkg::pau_stat_t stat;

  // margin register accepts a write on any cycle
  assign cfg_ready = 1'b1;

  pau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pau_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_epsilon_margin (cfg_epsilon_margin),
    .in_cand_makespan   (in_cand_makespan),
    .in_cand_energy     (in_cand_energy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_makespan (out_entry_makespan),
    .out_entry_energy   (out_entry_energy),
    .out_entry_slot     (out_entry_slot),
    .out_last_entry     (out_last_entry),
    .out_accepted       (out_accepted),
    .out_removed_count  (out_removed_count),
    .out_archive_count  (out_archive_count),
    .out_overflow       (out_overflow)
  );

endmodule

@@ src/pau_ctrl.sv @@
// ----------------------------------------------------------------------------
// pau_ctrl: update sequencer
// Steps each request through scan, append and prime phases, then a stream phase unless the archive is empty.
// ----------------------------------------------------------------------------
module pau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pau_pkg::pau_stat_t stat,
  output pau_pkg::pau_cmd_t  cmd
);

  pau_pkg::pau_state_t state_r;
  pau_pkg::pau_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pau_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = pau_pkg::ST_SCAN;
        end
      end
      pau_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = pau_pkg::ST_APPEND;
        end
      end
      pau_pkg::ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = pau_pkg::ST_PRIME;
      end
      pau_pkg::ST_PRIME: begin
        // nothing to stream if the archive is empty
        if (stat.empty) begin
          state_nxt = pau_pkg::ST_IDLE;
        end else begin
          cmd.prime = 1'b1;
          state_nxt = pau_pkg::ST_STREAM;
        end
      end
      pau_pkg::ST_STREAM: begin
        cmd.stream = 1'b1;
        if (stat.stream_end) begin
          state_nxt = pau_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pau_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/pau_dp.sv @@
// ----------------------------------------------------------------------------
// pau_dp: archive datapath
// Holds the archive memories, the margin register, the scan pipeline with
// in-place compaction and the output register of the result stream.
// ----------------------------------------------------------------------------
module pau_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pau_pkg::pau_cmd_t             cmd,
  output pau_pkg::pau_stat_t            stat,
  input  logic                          cfg_valid,
  input  logic [pau_pkg::EPS_W-1:0]     cfg_epsilon_margin,
  input  logic [pau_pkg::DATA_W-1:0]    in_cand_makespan,
  input  logic [pau_pkg::DATA_W-1:0]    in_cand_energy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pau_pkg::DATA_W-1:0]    out_entry_makespan,
  output logic [pau_pkg::DATA_W-1:0]    out_entry_energy,
  output logic [pau_pkg::SLOT_W-1:0]    out_entry_slot,
  output logic                          out_last_entry,
  output logic                          out_accepted,
  output logic [pau_pkg::COUNT_W-1:0]   out_removed_count,
  output logic [pau_pkg::COUNT_W-1:0]   out_archive_count,
  output logic                          out_overflow
);

  localparam int DataW  = pau_pkg::DATA_W;
  localparam int SumW   = pau_pkg::SUM_W;
  localparam int IdxW   = pau_pkg::IDX_W;
  localparam int CntW   = pau_pkg::CNT_W;
  localparam int SlotW  = pau_pkg::SLOT_W;
  localparam int CountW = pau_pkg::COUNT_W;
  localparam int Depth  = pau_pkg::ARCHIVE_DEPTH;

  logic [DataW-1:0] mem_m [Depth];
  logic [DataW-1:0] mem_e [Depth];

  logic [pau_pkg::EPS_W-1:0] eps_r;
  logic [DataW-1:0] cand_m_r, cand_e_r;
  logic [DataW-1:0] rd_m_r, rd_e_r;
  logic [CntW-1:0]  count_r, r_r, w_r, removed_r, k_r;
  logic             vld_r, reject_r, accepted_r, overflow_r, out_vld_r;

  logic [SumW-1:0]  cm_ext, ce_ext, em_ext, ee_ext, eps_ext;
  logic             better, worse, remove, set_rej;
  logic             issue, room, fire, last;
  logic             wr_en, rd_en;
  logic [IdxW-1:0]  wr_addr, rd_addr;
  logic [DataW-1:0] wr_m, wr_e;

  // margin register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= pau_pkg::EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_epsilon_margin;
    end
  end

  // exact margin tests: entry - cand > eps and cand - entry > eps
  assign cm_ext  = {1'b0, cand_m_r};
  assign ce_ext  = {1'b0, cand_e_r};
  assign em_ext  = {1'b0, rd_m_r};
  assign ee_ext  = {1'b0, rd_e_r};
  assign eps_ext = SumW'(eps_r);
  assign better  = (em_ext > cm_ext + eps_ext) || (ee_ext > ce_ext + eps_ext);
  assign worse   = (cm_ext > em_ext + eps_ext) || (ce_ext > ee_ext + eps_ext);
  assign remove  = vld_r && !reject_r && better && !worse;
  assign set_rej = vld_r && !reject_r && !better;

  assign issue = cmd.scan && (r_r != count_r);
  assign room  = (w_r < CntW'(Depth));
  assign fire  = cmd.stream && out_vld_r && out_ready;
  assign last  = ((k_r + CntW'(1)) == count_r);

  // memory ports: one write, one registered read
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = w_r[IdxW-1:0];
    wr_m    = rd_m_r;
    wr_e    = rd_e_r;
    if (cmd.scan && vld_r && !remove) begin
      wr_en = 1'b1;
    end else if (cmd.append && !reject_r && room) begin
      wr_en = 1'b1;
      wr_m  = cand_m_r;
      wr_e  = cand_e_r;
    end
    rd_en   = issue || cmd.prime || (fire && !last);
    rd_addr = '0;
    if (cmd.scan) begin
      rd_addr = r_r[IdxW-1:0];
    end else if (cmd.stream) begin
      rd_addr = IdxW'(k_r + CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_m[wr_addr] <= wr_m;
      mem_e[wr_addr] <= wr_e;
    end
    if (rd_en) begin
      rd_m_r <= mem_m[rd_addr];
      rd_e_r <= mem_e[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        vld_r <= 1'b0;
      end else if (cmd.scan) begin
        vld_r <= issue;
      end
      if (cmd.append) begin
        count_r <= (!reject_r && room) ? CntW'(w_r + CntW'(1)) : w_r;
      end
      if (cmd.prime) begin
        out_vld_r <= 1'b1;
      end else if (fire && last) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // scan and stream bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cand_m_r   <= in_cand_makespan;
      cand_e_r   <= in_cand_energy;
      r_r        <= '0;
      w_r        <= '0;
      removed_r  <= '0;
      reject_r   <= 1'b0;
      accepted_r <= 1'b0;
      overflow_r <= 1'b0;
    end
    if (issue) begin
      r_r <= CntW'(r_r + CntW'(1));
    end
    if (cmd.scan && vld_r) begin
      if (remove) begin
        removed_r <= CntW'(removed_r + CntW'(1));
      end else begin
        w_r <= CntW'(w_r + CntW'(1));
      end
      if (set_rej) begin
        reject_r <= 1'b1;
      end
    end
    if (cmd.append && !reject_r) begin
      accepted_r <= room;
      overflow_r <= !room;
    end
    if (cmd.prime) begin
      k_r <= '0;
    end else if (fire && !last) begin
      k_r <= CntW'(k_r + CntW'(1));
    end
  end

  assign stat.scan_done  = (r_r == count_r) && !vld_r;
  assign stat.empty      = (count_r == '0);
  assign stat.stream_end = fire && last;

  assign out_valid          = out_vld_r;
  assign out_entry_makespan = rd_m_r;
  assign out_entry_energy   = rd_e_r;
  assign out_entry_slot     = SlotW'(k_r[IdxW-1:0]);
  assign out_last_entry     = last;
  assign out_accepted       = accepted_r;
  assign out_removed_count  = CountW'(removed_r);
  assign out_archive_count  = CountW'(count_r);
  assign out_overflow       = overflow_r;

endmodule

@@ src/pau_checker.sv @@
// ----------------------------------------------------------------------------
// pau_checker: port-level checks for the Pareto archive update block
// Watches the result stream and the input handshake over time.
// ----------------------------------------------------------------------------
module pau_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pau_pkg::DATA_W-1:0]    out_entry_makespan,
  input logic [pau_pkg::DATA_W-1:0]    out_entry_energy,
  input logic [pau_pkg::SLOT_W-1:0]    out_entry_slot,
  input logic                          out_last_entry,
  input logic                          out_accepted,
  input logic [pau_pkg::COUNT_W-1:0]   out_archive_count,
  input logic                          out_overflow
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_makespan)
      && $stable(out_entry_energy) && $stable(out_entry_slot))
    else $error("stalled result changed");

  // no new request taken while a stream is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready during result stream");

  // last marker sits exactly on the final slot
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_entry ==
      (({1'b0, out_entry_slot} + 7'd1) == out_archive_count)))
    else $error("last marker does not match archive count");

  // appended and overflow are exclusive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_overflow))
    else $error("accepted and overflow both set");

  // stream advances one slot at a time with no gap
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_entry |=> out_valid
      && (out_entry_slot == $past(out_entry_slot) + 6'd1)
      && $stable(out_archive_count))
    else $error("result stream skipped or stalled");

endmodule

bind pareto_archive_update pau_checker u_pau_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_entry_makespan (out_entry_makespan),
  .out_entry_energy   (out_entry_energy),
  .out_entry_slot     (out_entry_slot),
  .out_last_entry     (out_last_entry),
  .out_accepted       (out_accepted),
  .out_archive_count  (out_archive_count),
  .out_overflow       (out_overflow)
);

@@ verif/pareto_archive_update_tb.sv @@
// ----------------------------------------------------------------------------
// pareto_archive_update_tb: self-checking bench for the Pareto archive update
// Mirrors the archive in a tracker class that replays each taken candidate
// request, queues the archive rows the block must stream back, and compares
// every returned row field by field. Stimulus runs a directed sequence, a
// front that fills the archive to overflow, then mixed random phases under
// several margins, with random stalls on both channels in all but the last.
// ----------------------------------------------------------------------------
module pareto_archive_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               ARCHIVE_DEPTH = pau_pkg::ARCHIVE_DEPTH;
  localparam int               DATA_W        = pau_pkg::DATA_W;
  localparam int               SLOT_W        = pau_pkg::SLOT_W;
  localparam int               COUNT_W       = pau_pkg::COUNT_W;
  localparam int               EPS_W         = pau_pkg::EPS_W;
  localparam logic [EPS_W-1:0] EPS_RESET     = pau_pkg::EPS_RESET;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  // The longest correct silence is one scan of a full archive plus stall
  // bursts; the limit is set far above it.
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 2 * ARCHIVE_DEPTH + 16;
  localparam int FRONT_POINTS = 70;
  localparam int MIX_REQUESTS = 30;

  localparam logic [DATA_W-1:0] TOP = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] MID = 32'h4000_0000;

  typedef struct packed {
    logic [DATA_W-1:0]  makespan;
    logic [DATA_W-1:0]  energy;
    logic [SLOT_W-1:0]  slot;
    logic               last;
    logic               accepted;
    logic [COUNT_W-1:0] removed;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } archive_row_t;

  // Tracker: own copy of the archive and margin, plus the rows still owed.
  class ParetoTracker;
    logic [DATA_W-1:0] mk_store [ARCHIVE_DEPTH];
    logic [DATA_W-1:0] en_store [ARCHIVE_DEPTH];
    int unsigned       fill;
    logic [EPS_W-1:0]  margin;
    archive_row_t      rows_due [$];
    int unsigned       mismatches, requests, rejected, overflows, rows_checked;
    int unsigned       max_fill;

    function new();
      fill = 0;
      margin = EPS_RESET;
      mismatches = 0;
      requests = 0;
      rejected = 0;
      overflows = 0;
      rows_checked = 0;
      max_fill = 0;
    endfunction

    task flag(string what);
      mismatches++;
      $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // Replay one candidate: scan, compact, append, then queue the stream.
    function void take_candidate(logic [DATA_W-1:0] cm, logic [DATA_W-1:0] ce);
      longint      em, ee, d1, d2, eps;
      bit          better, worse, stop, acc, ovf;
      int unsigned r, w, removed;
      archive_row_t row;
      eps = longint'(margin);
      stop = 1'b0;
      acc = 1'b0;
      ovf = 1'b0;
      w = 0;
      removed = 0;
      for (r = 0; r < fill; r++) begin
        em = longint'(mk_store[r]);
        ee = longint'(en_store[r]);
        better = 1'b0;
        worse = 1'b1;
        if (!stop) begin
          d1 = em - longint'(cm);
          d2 = ee - longint'(ce);
          better = (d1 > eps) || (d2 > eps);
          worse = (-d1 > eps) || (-d2 > eps);
          if (!better)
            stop = 1'b1;
        end
        if (!stop && better && !worse) begin
          removed++;
        end else begin
          mk_store[w] = em[DATA_W-1:0];
          en_store[w] = ee[DATA_W-1:0];
          w++;
        end
      end
      fill = w;
      if (!stop) begin
        if (fill < ARCHIVE_DEPTH) begin
          mk_store[fill] = cm;
          en_store[fill] = ce;
          fill++;
          acc = 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end
      requests++;
      if (stop)
        rejected++;
      if (ovf)
        overflows++;
      if (fill > max_fill)
        max_fill = fill;
      for (r = 0; r < fill; r++) begin
        row.makespan = mk_store[r];
        row.energy = en_store[r];
        row.slot = r[SLOT_W-1:0];
        row.last = (r + 1 == fill);
        row.accepted = acc;
        row.removed = removed[COUNT_W-1:0];
        row.count = fill[COUNT_W-1:0];
        row.overflow = ovf;
        rows_due.insert(rows_due.size(), row);
      end
    endfunction

    task check_field(string name, logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] got,
                     logic [DATA_W-1:0] want);
      if (got !== want)
        flag($sformatf("row %0d %s: got %h, want %h", slot, name, got, want));
    endtask

    task match_row(archive_row_t got);
      archive_row_t want;
      if (rows_due.size() == 0) begin
        flag($sformatf("unexpected row at slot %0d", got.slot));
      end else begin
        want = rows_due.pop_front();
        rows_checked++;
        check_field("makespan", want.slot, got.makespan, want.makespan);
        check_field("energy", want.slot, got.energy, want.energy);
        check_field("slot", want.slot, DATA_W'(got.slot), DATA_W'(want.slot));
        check_field("last", want.slot, DATA_W'(got.last), DATA_W'(want.last));
        check_field("accepted", want.slot, DATA_W'(got.accepted),
                    DATA_W'(want.accepted));
        check_field("removed_count", want.slot, DATA_W'(got.removed),
                    DATA_W'(want.removed));
        check_field("archive_count", want.slot, DATA_W'(got.count),
                    DATA_W'(want.count));
        check_field("overflow", want.slot, DATA_W'(got.overflow),
                    DATA_W'(want.overflow));
      end
    endtask

    task close_out();
      if (rows_due.size() != 0)
        flag($sformatf("%0d archive rows never arrived", rows_due.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every block input starts at a known value.
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DATA_W-1:0]   in_cand_makespan = '0;
  logic [DATA_W-1:0]   in_cand_energy = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DATA_W-1:0]   out_entry_makespan;
  logic [DATA_W-1:0]   out_entry_energy;
  logic [SLOT_W-1:0]   out_entry_slot;
  logic                out_last_entry;
  logic                out_accepted;
  logic [COUNT_W-1:0]  out_removed_count;
  logic [COUNT_W-1:0]  out_archive_count;
  logic                out_overflow;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [EPS_W-1:0]    cfg_epsilon_margin = '0;

  ParetoTracker  sb;
  bit            idle_on = 1'b1;
  int unsigned   stall_left = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   margins_used = 0;
  archive_row_t  seen_row;

  pareto_archive_update DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cand_makespan   (in_cand_makespan),
    .in_cand_energy     (in_cand_energy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_makespan (out_entry_makespan),
    .out_entry_energy   (out_entry_energy),
    .out_entry_slot     (out_entry_slot),
    .out_last_entry     (out_last_entry),
    .out_accepted       (out_accepted),
    .out_removed_count  (out_removed_count),
    .out_archive_count  (out_archive_count),
    .out_overflow       (out_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_epsilon_margin (cfg_epsilon_margin)
  );

  // 8 ns clock.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Receiver: hold out_ready low in random bursts while idling is enabled;
  // drive it high throughout otherwise.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sample each taken result request at the rising edge and check it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_row.makespan = out_entry_makespan;
      seen_row.energy = out_entry_energy;
      seen_row.slot = out_entry_slot;
      seen_row.last = out_last_entry;
      seen_row.accepted = out_accepted;
      seen_row.removed = out_removed_count;
      seen_row.count = out_archive_count;
      seen_row.overflow = out_overflow;
      sb.match_row(seen_row);
    end
  end

  // Watchdog: count cycles with no handshake on any channel; abandon the
  // run once the count reaches the limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Clamp a wide intermediate into the 32-bit objective range.
  function automatic logic [DATA_W-1:0] clamp32(longint v);
    if (v < 0)
      return '0;
    if (v > longint'(TOP))
      return TOP;
    return v[DATA_W-1:0];
  endfunction

  // Present one candidate request; leave valid high after it is taken so the
  // next call can follow on without a gap.
  task automatic send_cand(logic [DATA_W-1:0] m, logic [DATA_W-1:0] e);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cand_makespan <= m;
    in_cand_energy <= e;
    do @(posedge clk); while (!in_ready);
    sb.take_candidate(m, e);
  endtask

  // Drop valid and hold off until every owed row has come and the block is
  // ready for the next request again.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.rows_due.size() != 0 || !in_ready) @(negedge clk);
  endtask

  // Write the margin register; only called with the block idle.
  task automatic write_margin(logic [EPS_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_epsilon_margin <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.margin = v;
    margins_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Directed sequence under the reset margin of 0.5: duplicates, the margin
  // boundary, removals at both extremes, a candidate that removes an entry
  // and is then rejected by a later one, and a multi-entry removal.
  task automatic run_directed();
    send_cand(TOP, TOP);                  // empty archive accepts
    send_cand(TOP, TOP);                  // exact duplicate rejected
    send_cand(TOP - 8, TOP - 8);          // within margin on both: rejected
    send_cand(TOP - 9, TOP);              // just past margin: replaces entry
    send_cand('0, TOP);                   // zero makespan removes it
    send_cand(TOP, '0);                   // trade-off appended
    send_cand(TOP - 8, 32'd7);            // within margin of last entry
    send_cand(TOP - 9, '0);               // removes the last entry only
    send_cand(32'h8000_0000, 32'h8000_0000);
    send_cand(MID, MID);                  // removes the midpoint
    send_cand(MID + 10, MID - 50);        // trade-off appended
    send_cand(MID + 5, MID - 45);         // removes one, then rejected
    send_cand(MID - 500, MID + 2000);
    send_cand(MID + 2000, MID - 500);
    send_cand(MID - 600, MID - 600);      // removes three in one scan
    send_cand(MID - 592, MID - 592);      // on the margin: rejected
    send_cand(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_cand(32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_cand(32'h7FFF_0000, 32'h0000_0010);
  endtask

  // With a zero margin, walk a line of mutual trade-offs in shuffled order
  // until the archive fills and later points overflow, then sweep the line
  // away with one candidate that dominates all of it.
  task automatic run_front_fill();
    logic [DATA_W-1:0] m0, e0;
    int unsigned       s, off, i, j;
    s = $urandom_range(1, 32'h0001_0000);
    m0 = 32'h0100_0000 + $urandom_range(0, 16'hFFFF);
    e0 = 32'h3000_0000 - $urandom_range(0, 16'hFFFF);
    off = $urandom_range(0, FRONT_POINTS - 1);
    for (i = 0; i < FRONT_POINTS; i++) begin
      j = (i * 37 + off) % FRONT_POINTS;
      send_cand(m0 + j * s, e0 - j * s);
    end
    send_cand(m0 - 1 - $urandom_range(0, 255),
              e0 - (FRONT_POINTS - 1) * s - 1 - $urandom_range(0, 255));
  endtask

  // Mixed random phase. Most candidates are built from a random archive
  // entry: trade-offs along a line, near misses around the margin, and
  // sweeps just below it; the rest is full-range noise.
  task automatic run_mix(int unsigned n, int unsigned pause_at);
    int unsigned i, kind, idx, j;
    longint      xm, xe, eps, s, o1, o2;
    for (i = 0; i < n; i++) begin
      if (i == pause_at)
        wait_drained();
      kind = $urandom_range(0, 99);
      idx = $urandom_range(0, sb.fill - 1);
      xm = longint'(sb.mk_store[idx]);
      xe = longint'(sb.en_store[idx]);
      eps = longint'(sb.margin);
      if (kind < 30) begin
        j = $urandom_range(1, 8);
        s = eps + $urandom_range(1, 2 * sb.margin + 64);
        if ($urandom_range(0, 1))
          send_cand(clamp32(xm - j * s), clamp32(xe + j * s));
        else
          send_cand(clamp32(xm + j * s), clamp32(xe - j * s));
      end else if (kind < 50) begin
        o1 = longint'($urandom_range(0, 2 * sb.margin + 4)) - (eps + 2);
        o2 = longint'($urandom_range(0, 2 * sb.margin + 4)) - (eps + 2);
        send_cand(clamp32(xm + o1), clamp32(xe + o2));
      end else if (kind < 65) begin
        s = eps + $urandom_range(1, 64);
        send_cand(clamp32(xm - s), clamp32(xe - s));
      end else begin
        send_cand($urandom, $urandom);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, directed part, overflow fill, random phases under
  // several margins, then drain and report.
  // --------------------------------------------------------------------------
  initial begin
    logic [EPS_W-1:0] mix_margin [4];
    int unsigned      p;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    wait_drained();
    write_margin('0);
    run_front_fill();

    mix_margin[0] = 16'hFFFF;
    mix_margin[1] = EPS_W'($urandom_range(1, 255));
    mix_margin[2] = EPS_W'($urandom);
    mix_margin[3] = EPS_RESET;
    for (p = 0; p < 4; p++) begin
      wait_drained();
      write_margin(mix_margin[p]);
      // The final phase runs with both sides flat out.
      if (p == 3)
        idle_on = 1'b0;
      run_mix(MIX_REQUESTS, (p == 1) ? MIX_REQUESTS / 2 : MIX_REQUESTS);
    end

    // Drain, then keep watching for stray rows for a full update's worth.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close_out();

    $display("Covered %0d candidates, %0d margin writes, %0d rejected, %0d dropped when full.",
             sb.requests, margins_used, sb.rejected, sb.overflows);
    $display("Checked %0d archive rows; largest archive held %0d entries; %0d mismatches.",
             sb.rows_checked, sb.max_fill, sb.mismatches);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ pareto_archive_update.f @@
src/pau_pkg.sv
src/pau_ctrl.sv
src/pau_dp.sv
src/pareto_archive_update.sv
src/pau_checker.sv
verif/pareto_archive_update_tb.sv
